@@ design/xor_keystream_byte_decryptor_macros.svh @@
// Assertion macros shared by the decryptor modules.
// Define ASSERT_OFF to compile the checks away.
`ifndef XOR_KEYSTREAM_BYTE_DECRYPTOR_MACROS_SVH
`define XOR_KEYSTREAM_BYTE_DECRYPTOR_MACROS_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define XKD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xkd assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define XKD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xkd assertion failed");
`else
`define XKD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define XKD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/xkd_pkg.sv @@
// Shared constants and types for the XOR keystream byte decryptor.
// No dependencies.
package xkd_pkg;

  localparam int KEY_W  = 64;
  localparam int HALF_W = KEY_W / 2;
  localparam int BYTE_W = 8;
  localparam int CFG_INDEX_W = 1;

  localparam logic [KEY_W-1:0] LCG_MULT = 64'd6364136223846793005;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_KEY  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_OVERRIDE = 1'd1;

  // Status of the key stepping unit.
  typedef struct packed {
    logic             ready;
    logic [KEY_W-1:0] next_key;
  } lcg_status_t;

endpackage

@@ design/xkd_lcg_step.sv @@
// Multi-cycle key stepper: next_key = key * LCG_MULT + 1 mod 2^64.
// Uses one shared 32x32 multiplier; depends on xkd_pkg.
`include "xor_keystream_byte_decryptor_macros.svh"
module xkd_lcg_step (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     restart,
  input  logic [xkd_pkg::KEY_W-1:0] key,
  output xkd_pkg::lcg_status_t     status
);

  localparam int HW = xkd_pkg::HALF_W;

  localparam logic [2:0] PH_LL   = 3'd0;
  localparam logic [2:0] PH_HL   = 3'd1;
  localparam logic [2:0] PH_LH   = 3'd2;
  localparam logic [2:0] PH_SUM  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0]                phase;
  logic [2:0]                phase_next;
  logic [HW-1:0]             mul_a;
  logic [HW-1:0]             mul_b;
  logic [xkd_pkg::KEY_W-1:0] mul_p;
  logic [xkd_pkg::KEY_W-1:0] prod;
  logic [xkd_pkg::KEY_W-1:0] acc;

  // Operand selection for the three partial products that survive mod 2^64.
  always_comb begin
    mul_a = key[HW-1:0];
    mul_b = xkd_pkg::LCG_MULT[HW-1:0];
    phase_next = phase;
    unique case (phase)
      PH_LL: begin
        phase_next = PH_HL;
      end
      PH_HL: begin
        mul_a = key[xkd_pkg::KEY_W-1:HW];
        phase_next = PH_LH;
      end
      PH_LH: begin
        mul_b = xkd_pkg::LCG_MULT[xkd_pkg::KEY_W-1:HW];
        phase_next = PH_SUM;
      end
      PH_SUM: begin
        phase_next = PH_DONE;
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_LL;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase <= PH_LL;
    end else begin
      phase <= phase_next;
    end
  end

  // The product is registered before it is added into the sum.
  always_ff @(posedge clk) begin
    case (phase)
      PH_LL: begin
        prod <= mul_p;
      end
      PH_HL: begin
        acc  <= prod + xkd_pkg::KEY_W'(1);
        prod <= {{HW{1'b0}}, mul_p[HW-1:0]};
      end
      PH_LH: begin
        acc  <= acc + {prod[HW-1:0], {HW{1'b0}}};
        prod <= {{HW{1'b0}}, mul_p[HW-1:0]};
      end
      PH_SUM: begin
        acc  <= acc + {prod[HW-1:0], {HW{1'b0}}};
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign status.ready    = (phase == PH_DONE);
  assign status.next_key = acc;

  `XKD_ASSERT_NEXT(a_ready_holds, clk, rst, status.ready && !restart, status.ready)
  `XKD_ASSERT_NEXT(a_restart_clears_ready, clk, rst, restart, !status.ready)
  `XKD_ASSERT_NEXT(a_sum_then_done, clk, rst, phase == PH_SUM && !restart, status.ready)

endmodule

@@ design/xkd_out_skid.sv @@
// Two-entry output buffer that decouples the result channel stall from the input.
// Depends on xkd_pkg.
`include "xor_keystream_byte_decryptor_macros.svh"
module xkd_out_skid (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [xkd_pkg::BYTE_W-1:0] push_data,
  output logic                      full,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [xkd_pkg::BYTE_W-1:0] out_data
);

  logic                       main_valid;
  logic                       skid_valid;
  logic [xkd_pkg::BYTE_W-1:0] main_data;
  logic [xkd_pkg::BYTE_W-1:0] skid_data;
  logic                       pop;

  assign pop = main_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // No push can arrive while the skid entry is occupied.
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  `XKD_ASSERT_IMPL(a_skid_implies_main, clk, rst, skid_valid, main_valid)
  `XKD_ASSERT_IMPL(a_no_push_when_full, clk, rst, skid_valid, !push)
  `XKD_ASSERT_NEXT(a_skid_drains_to_main, clk, rst, skid_valid && pop, main_valid && !skid_valid)

endmodule

@@ design/xor_keystream_byte_decryptor.sv @@
// Top level of the XOR keystream byte decryptor: key and counter state,
// keystream selection, key stepper and output buffer. Depends on xkd_pkg.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_stall, cipher_byte, message_start | in
//   result  | out_valid, out_stall, plain_byte          | out
//   config  | cfg_we, cfg_index, cfg_data               | in
//
// One byte is taken per cycle unless in_stall is high; its result is registered in the output buffer.
// The key step multiply runs through the LL, HL, LH and SUM phases on one 32x32 multiplier after
// every key load or step, and is always finished before the counter next wraps.
// in_stall rises only when both output entries are full; the skid entry absorbs one byte taken during an output stall.
// Synchronous reset clears key, counter, registers and the output buffer at once.
`include "xor_keystream_byte_decryptor_macros.svh"
module xor_keystream_byte_decryptor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [xkd_pkg::BYTE_W-1:0]     cipher_byte,
  input  logic                           message_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [xkd_pkg::BYTE_W-1:0]     plain_byte,
  input  logic                           cfg_we,
  input  logic [xkd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xkd_pkg::KEY_W-1:0]      cfg_data
);

  logic [xkd_pkg::KEY_W-1:0]  default_key;
  logic [xkd_pkg::KEY_W-1:0]  key_override;
  logic [xkd_pkg::KEY_W-1:0]  working_key;
  logic [xkd_pkg::BYTE_W-1:0] byte_counter;

  logic [xkd_pkg::KEY_W-1:0]  key_sel;
  logic [xkd_pkg::BYTE_W-1:0] cnt_sel;
  logic [xkd_pkg::BYTE_W-1:0] ks_byte;
  logic [xkd_pkg::BYTE_W-1:0] plain_next;
  logic                       accept;
  logic                       wrap;
  logic                       key_load;
  xkd_pkg::lcg_status_t       lcg_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_key  <= '0;
      key_override <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xkd_pkg::REG_DEFAULT_KEY:  default_key  <= cfg_data;
        xkd_pkg::REG_KEY_OVERRIDE: key_override <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid && !in_stall;

  // A message start reloads the key and restarts the count for this very byte.
  always_comb begin
    if (message_start) begin
      key_sel = (key_override != '0) ? key_override : default_key;
      cnt_sel = '0;
    end else begin
      key_sel = working_key;
      cnt_sel = byte_counter;
    end
  end

  assign ks_byte    = key_sel[{cnt_sel[2:0], 3'b000} +: xkd_pkg::BYTE_W] ^ cnt_sel;
  assign plain_next = cipher_byte ^ ks_byte;
  assign wrap       = (cnt_sel == {xkd_pkg::BYTE_W{1'b1}});
  assign key_load   = accept && (message_start || wrap);

  always_ff @(posedge clk) begin
    if (rst) begin
      working_key  <= '0;
      byte_counter <= '0;
    end else if (accept) begin
      byte_counter <= cnt_sel + xkd_pkg::BYTE_W'(1);
      if (wrap) begin
        working_key <= lcg_status.next_key;
      end else if (message_start) begin
        working_key <= key_sel;
      end
    end
  end

  xkd_lcg_step u_lcg (
    .clk     (clk),
    .rst     (rst),
    .restart (key_load),
    .key     (working_key),
    .status  (lcg_status)
  );

  xkd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (plain_next),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (plain_byte)
  );

  `XKD_ASSERT_IMPL(a_key_ready_at_wrap, clk, rst, accept && wrap, lcg_status.ready)
  `XKD_ASSERT_NEXT(a_counter_clears_on_wrap, clk, rst, accept && wrap, byte_counter == '0)
  `XKD_ASSERT_NEXT(a_start_counts_one, clk, rst, accept && message_start, byte_counter == 8'd1)

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for xor_keystream_byte_decryptor: drives byte transfers and key
// writes, predicts every plain byte and compares it at the result port.
// Depends on xkd_pkg and the decryptor RTL.
module tb_top;

  localparam logic [xkd_pkg::KEY_W-1:0] KEY_STEP_MULT = 64'd6364136223846793005;
  localparam logic [xkd_pkg::KEY_W-1:0] ALL_ONES      = {xkd_pkg::KEY_W{1'b1}};
  localparam int                        HOLD_CYCLES   = 200;
  localparam int                        DRAIN_CYCLES  = 8;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [xkd_pkg::BYTE_W-1:0]      cipher_byte;
  logic                            message_start;
  logic                            out_valid;
  logic                            out_stall;
  logic [xkd_pkg::BYTE_W-1:0]      plain_byte;
  logic                            cfg_we;
  logic [xkd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [xkd_pkg::KEY_W-1:0]       cfg_data;

  // Predictor state: shadow registers, working key and byte counter.
  logic [xkd_pkg::KEY_W-1:0]  reg_default;
  logic [xkd_pkg::KEY_W-1:0]  reg_override;
  logic [xkd_pkg::KEY_W-1:0]  cur_key;
  logic [xkd_pkg::BYTE_W-1:0] cur_count;

  logic [xkd_pkg::BYTE_W-1:0] plain_q[$];

  int  fail_count  = 0;
  int  n_sent      = 0;
  int  n_checked   = 0;
  int  n_starts    = 0;
  int  n_key_steps = 0;
  bit  tx_idle_en  = 1'b1;
  bit  rx_idle_en  = 1'b1;
  bit  hold_req    = 1'b0;

  xor_keystream_byte_decryptor i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cipher_byte   (cipher_byte),
    .message_start (message_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .plain_byte    (plain_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #3000000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic [xkd_pkg::KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Advances the predicted decryptor by one byte and returns the plain byte.
  function automatic logic [xkd_pkg::BYTE_W-1:0] decrypt_byte(
      input logic [xkd_pkg::BYTE_W-1:0] c, input logic s);
    logic [xkd_pkg::BYTE_W-1:0] ks;
    if (s) begin
      cur_key   = (reg_override != '0) ? reg_override : reg_default;
      cur_count = '0;
      n_starts++;
    end
    ks = cur_key[cur_count[2:0]*8 +: 8] ^ cur_count;
    cur_count = cur_count + 8'd1;
    if (cur_count == '0) begin
      cur_key = cur_key * KEY_STEP_MULT + 64'd1;
      n_key_steps++;
    end
    return c ^ ks;
  endfunction

  // Result side: random stall bursts, or one long hold when asked for.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic [xkd_pkg::BYTE_W-1:0] want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (plain_q.size() == 0) begin
        $error("plain_byte: expected none, actual %02h", plain_byte);
        fail_count++;
      end else begin
        want = plain_q.pop_front();
        n_checked++;
        if (plain_byte !== want) begin
          $error("plain_byte: expected %02h, actual %02h", want, plain_byte);
          fail_count++;
        end
      end
    end
  end

  task automatic send_byte(input logic [xkd_pkg::BYTE_W-1:0] c, input logic s);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cipher_byte   <= c;
    message_start <= s;
    do @(posedge clk); while (in_stall);
    plain_q.insert(plain_q.size(), decrypt_byte(c, s));
    n_sent++;
  endtask

  task automatic send_message(input int len, input bit with_start);
    for (int i = 0; i < len; i++) begin
      send_byte(xkd_pkg::BYTE_W'($urandom_range(0, 255)), with_start && i == 0);
    end
  endtask

  // Drops valid and waits until every predicted byte has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (plain_q.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_keys(input logic [xkd_pkg::KEY_W-1:0] dflt,
                          input logic [xkd_pkg::KEY_W-1:0] ovr);
    cfg_we    <= 1'b1;
    cfg_index <= xkd_pkg::REG_DEFAULT_KEY;
    cfg_data  <= dflt;
    @(posedge clk);
    reg_default = dflt;
    cfg_index <= xkd_pkg::REG_KEY_OVERRIDE;
    cfg_data  <= ovr;
    @(posedge clk);
    reg_override = ovr;
    cfg_we <= 1'b0;
  endtask

  // Right after reset the key and counter are zero, so bytes without a start still decrypt.
  task automatic test_before_start();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
  endtask

  task automatic test_key_selection();
    wait_idle();
    set_keys(ALL_ONES, '0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    wait_idle();
    set_keys(ALL_ONES, 64'h1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    wait_idle();
    set_keys('0, ALL_ONES);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    wait_idle();
    set_keys('0, '0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h81, 1'b0);
  endtask

  // New register values must not disturb the key already loaded for a running message.
  task automatic test_write_mid_message();
    wait_idle();
    set_keys(64'h0123_4567_89AB_CDEF, '0);
    send_byte(8'hC3, 1'b1);
    send_byte(8'h3C, 1'b0);
    wait_idle();
    set_keys(64'hFEDC_BA98_7654_3210, 64'h0F1E_2D3C_4B5A_6978);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'h66, 1'b1);
  endtask

  task automatic run_random_phase(input logic [xkd_pkg::KEY_W-1:0] dflt,
                                  input logic [xkd_pkg::KEY_W-1:0] ovr,
                                  input int n_items);
    int left;
    int len;
    wait_idle();
    set_keys(dflt, ovr);
    left = n_items;
    // Open with one long message, clipped to the items left in the phase.
    len = $urandom_range(257, 520);
    while (left > 0) begin
      if (len > left) len = left;
      send_message(len, $urandom_range(0, 9) != 0);
      left -= len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 40);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(rand_key(), '0, 220);
    run_random_phase(rand_key(), rand_key(), 220);
    run_random_phase('0, rand_key(), 220);
    run_random_phase(ALL_ONES, ALL_ONES, 220);
    run_random_phase(rand_key(), 64'h1, 220);
    run_random_phase(64'h8000_0000_0000_0000, '0, 220);
    run_random_phase('0, '0, 220);
  endtask

  // The result side holds off for a long time while bytes keep coming at full rate.
  task automatic test_backpressure();
    wait_idle();
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    send_message(300, 1'b1);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_full_rate();
    wait_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_keys(rand_key(), '0);
    send_message(280, 1'b1);
    send_message(20, 1'b1);
  endtask

  initial begin
    reg_default   = '0;
    reg_override  = '0;
    cur_key       = '0;
    cur_count     = '0;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    cipher_byte   <= '0;
    message_start <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= xkd_pkg::REG_DEFAULT_KEY;
    cfg_data      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_before_start();
    test_key_selection();
    test_write_mid_message();
    test_random_traffic();
    test_backpressure();
    test_full_rate();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d of %0d bytes over %0d message starts and %0d key steps,",
             n_checked, n_sent, n_starts, n_key_steps);
    $display("with default and override key settings, a long result hold and full-rate traffic.");
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/xkd_pkg.sv
design/xkd_lcg_step.sv
design/xkd_out_skid.sv
design/xor_keystream_byte_decryptor.sv
verif/tb_top.sv
